// ----- rtl/amic_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// amic_pkg: shared types and constants for the affine inverse core
// Word format, intermediate widths and small helpers for the datapath.
// ----------------------------------------------------------------------------
package amic_pkg;

  localparam int WORD_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int DET_W      = PROD_W + 1;
  localparam int MAT_NUM_W  = WORD_W + 2 * FRAC_W;
  localparam int TR_NUM_W   = DET_W + FRAC_W;
  localparam int NUM_W      = (MAT_NUM_W > TR_NUM_W) ? MAT_NUM_W : TR_NUM_W;
  localparam int DEN_W      = DET_W;
  localparam int CMP_W      = (NUM_W > DEN_W + WORD_W) ? NUM_W : DEN_W + WORD_W;
  localparam int LANES      = 6;
  localparam int DIV_STAGES = WORD_W + 1;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DET_W-1:0]  det_t;

  // Magnitude of a numerator and the sign of the final quotient.
  typedef struct packed {
    logic [NUM_W-1:0] mag;
    logic             neg;
  } num_t;

  typedef struct packed {
    logic [LANES-1:0][WORD_W-1:0] val;
    logic                         singular;
    logic                         overflow;
  } res_t;

  function automatic logic [WORD_W:0] abs_word(word_t x);
    logic [WORD_W:0] ext;
    ext = {x[WORD_W-1], x};
    return x[WORD_W-1] ? (~ext + 1'b1) : ext;
  endfunction

  function automatic logic [DET_W-1:0] abs_det(det_t x);
    return x[DET_W-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/amic_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// amic_front: products, determinant and numerators
// Three stages: six signed products, the determinant and translation terms,
// then magnitudes and quotient signs for the six division lanes.
// ----------------------------------------------------------------------------
module amic_front
  import amic_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  v_i,
  input  wire word_t                 a_i,
  input  wire word_t                 b_i,
  input  wire word_t                 c_i,
  input  wire word_t                 d_i,
  input  wire word_t                 e_i,
  input  wire word_t                 f_i,
  output logic                       v_o,
  output logic                       singular_o,
  output logic [DEN_W-1:0]           den_o,
  output num_t [LANES-1:0]           num_o
);

  logic  v1_r, v2_r, v3_r;
  prod_t pad_r, pbc_r, pcf_r, pde_r, pbe_r, paf_r;
  word_t a1_r, b1_r, c1_r, d1_r;
  det_t  det2_r, te2_r, tf2_r;
  word_t a2_r, b2_r, c2_r, d2_r;
  logic  sing3_r;
  logic [DEN_W-1:0] den3_r;
  num_t [LANES-1:0] num3_r;
  logic  dneg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pad_r <= PROD_W'(a_i) * PROD_W'(d_i);
      pbc_r <= PROD_W'(b_i) * PROD_W'(c_i);
      pcf_r <= PROD_W'(c_i) * PROD_W'(f_i);
      pde_r <= PROD_W'(d_i) * PROD_W'(e_i);
      pbe_r <= PROD_W'(b_i) * PROD_W'(e_i);
      paf_r <= PROD_W'(a_i) * PROD_W'(f_i);
      a1_r  <= a_i;
      b1_r  <= b_i;
      c1_r  <= c_i;
      d1_r  <= d_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det2_r <= DET_W'(pad_r) - DET_W'(pbc_r);
      te2_r  <= DET_W'(pcf_r) - DET_W'(pde_r);
      tf2_r  <= DET_W'(pbe_r) - DET_W'(paf_r);
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      c2_r   <= c1_r;
      d2_r   <= d1_r;
    end
  end

  assign dneg = det2_r[DET_W-1];

  // The off-diagonal entries are negated, so their sign flips before the divide.
  always_ff @(posedge clk) begin
    if (en) begin
      sing3_r       <= (det2_r == '0);
      den3_r        <= abs_det(det2_r);
      num3_r[0].mag <= NUM_W'(abs_word(d2_r)) << (2 * FRAC_W);
      num3_r[0].neg <= d2_r[WORD_W-1] ^ dneg;
      num3_r[1].mag <= NUM_W'(abs_word(b2_r)) << (2 * FRAC_W);
      num3_r[1].neg <= ~b2_r[WORD_W-1] ^ dneg;
      num3_r[2].mag <= NUM_W'(abs_word(c2_r)) << (2 * FRAC_W);
      num3_r[2].neg <= ~c2_r[WORD_W-1] ^ dneg;
      num3_r[3].mag <= NUM_W'(abs_word(a2_r)) << (2 * FRAC_W);
      num3_r[3].neg <= a2_r[WORD_W-1] ^ dneg;
      num3_r[4].mag <= NUM_W'(abs_det(te2_r)) << FRAC_W;
      num3_r[4].neg <= te2_r[DET_W-1] ^ dneg;
      num3_r[5].mag <= NUM_W'(abs_det(tf2_r)) << FRAC_W;
      num3_r[5].neg <= tf2_r[DET_W-1] ^ dneg;
    end
  end

  assign v_o        = v3_r;
  assign singular_o = sing3_r;
  assign den_o      = den3_r;
  assign num_o      = num3_r;

endmodule

`default_nettype wire

// ----- rtl/amic_div_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// amic_div_lane: pipelined restoring divider for one quotient
// A range check stage, then one quotient bit per stage, most significant first.
// ----------------------------------------------------------------------------
module amic_div_lane
  import amic_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire num_t              num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  output logic [WORD_W-1:0]      q_o,
  output logic                   neg_o,
  output logic                   ovf_o
);

  logic [NUM_W-1:0]  rem_r [DIV_STAGES];
  logic [DEN_W-1:0]  den_r [DIV_STAGES];
  logic [WORD_W-1:0] q_r   [DIV_STAGES];
  logic              neg_r [DIV_STAGES];
  logic              ovf_r [DIV_STAGES];

  // A quotient of 2^WORD_W or more can never fit; flag it up front so the
  // bit steps only need to cover the word.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_i.mag;
      den_r[0] <= den_i;
      q_r[0]   <= '0;
      neg_r[0] <= num_i.neg;
      ovf_r[0] <= CMP_W'(num_i.mag) >= (CMP_W'(den_i) << WORD_W);
    end
  end

  for (genvar j = 1; j < DIV_STAGES; j++) begin : g_step
    localparam int SH = WORD_W - j;
    logic [CMP_W-1:0] trial;
    logic [CMP_W-1:0] rem_ext;
    logic             ge;

    assign trial   = CMP_W'(den_r[j-1]) << SH;
    assign rem_ext = CMP_W'(rem_r[j-1]);
    assign ge      = rem_ext >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? NUM_W'(rem_ext - trial) : rem_r[j-1];
        den_r[j] <= den_r[j-1];
        q_r[j]   <= {q_r[j-1][WORD_W-2:0], ge};
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  assign q_o   = q_r[DIV_STAGES-1];
  assign neg_o = neg_r[DIV_STAGES-1];
  assign ovf_o = ovf_r[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/affine_matrix_inverse_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// affine_matrix_inverse_core: inverse of a 2D affine matrix, signed fixed point
// Six truncating quotients over the determinant, saturated to the word.
// ----------------------------------------------------------------------------
//   channel | ports                               | direction
//   input   | in_valid/in_ready, in_a..in_f       | to core
//   result  | out_valid/out_ready, out_a..out_f,  | from core
//           | out_singular, out_overflow          |
//
// One matrix per cycle is taken while in_ready is high. Each matrix passes
// three front stages, the range check and 32 quotient-bit stages of each
// divider lane, the saturation stage and the output register before out_valid.
// Reset (synchronous, active low) clears only the valid bits.
// A result arriving at a stalled output goes to a skid register; in_ready falls
// only while the skid register is full, and then the whole pipeline holds.
module affine_matrix_inverse_core
  import amic_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire word_t in_a,
  input  wire word_t in_b,
  input  wire word_t in_c,
  input  wire word_t in_d,
  input  wire word_t in_e,
  input  wire word_t in_f,
  output logic       out_valid,
  input  wire logic  out_ready,
  output word_t      out_a,
  output word_t      out_b,
  output word_t      out_c,
  output word_t      out_d,
  output word_t      out_e,
  output word_t      out_f,
  output logic       out_singular,
  output logic       out_overflow
);

  logic             en;
  logic             fv;
  logic             fsing;
  logic [DEN_W-1:0] fden;
  num_t [LANES-1:0] fnum;

  logic [LANES-1:0][WORD_W-1:0] lq;
  logic [LANES-1:0]             lneg;
  logic [LANES-1:0]             lovf;

  logic dv_r [DIV_STAGES];
  logic ds_r [DIV_STAGES];

  logic fin_v_r;
  res_t fin_r;
  res_t fin_nxt;
  logic out_v_r;
  res_t out_r;
  logic skid_v_r;
  res_t skid_r;
  logic take;

  assign en       = !skid_v_r;
  assign in_ready = en;

  amic_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .v_i        (in_valid),
    .a_i        (in_a),
    .b_i        (in_b),
    .c_i        (in_c),
    .d_i        (in_d),
    .e_i        (in_e),
    .f_i        (in_f),
    .v_o        (fv),
    .singular_o (fsing),
    .den_o      (fden),
    .num_o      (fnum)
  );

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    amic_div_lane u_lane (
      .clk   (clk),
      .en    (en),
      .num_i (fnum[k]),
      .den_i (fden),
      .q_o   (lq[k]),
      .neg_o (lneg[k]),
      .ovf_o (lovf[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else if (en) begin
      dv_r[0] <= fv;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds_r[0] <= fsing;
      for (int i = 1; i < DIV_STAGES; i++) begin
        ds_r[i] <= ds_r[i-1];
      end
    end
  end

  // Saturation: a negative quotient may reach one past the positive limit.
  always_comb begin
    logic [LANES-1:0] sat;
    logic             sg;
    sg = ds_r[DIV_STAGES-1];
    for (int k = 0; k < LANES; k++) begin
      if (lneg[k]) begin
        sat[k] = lovf[k] || (lq[k][WORD_W-1] && (|lq[k][WORD_W-2:0]));
        fin_nxt.val[k] = sat[k] ? {1'b1, {(WORD_W-1){1'b0}}} : (~lq[k] + 1'b1);
      end else begin
        sat[k] = lovf[k] || lq[k][WORD_W-1];
        fin_nxt.val[k] = sat[k] ? {1'b0, {(WORD_W-1){1'b1}}} : lq[k];
      end
      if (sg) begin
        fin_nxt.val[k] = '0;
      end
    end
    fin_nxt.singular = sg;
    fin_nxt.overflow = (|sat) && !sg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= dv_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  assign take = en && fin_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_ready) begin
      if (take) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_ready) begin
      if (take) begin
        skid_r <= fin_r;
      end
    end else if (skid_v_r) begin
      out_r <= skid_r;
    end else if (take) begin
      out_r <= fin_r;
    end
  end

  assign out_valid    = out_v_r;
  assign out_a        = out_r.val[0];
  assign out_b        = out_r.val[1];
  assign out_c        = out_r.val[2];
  assign out_d        = out_r.val[3];
  assign out_e        = out_r.val[4];
  assign out_f        = out_r.val[5];
  assign out_singular = out_r.singular;
  assign out_overflow = out_r.overflow;

`ifndef SYNTH
  a_sing_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> !out_overflow && out_a == '0 && out_f == '0)
    else $error("singular result carries nonzero data or overflow");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register empty");

  a_stall_holds_fin: assert property (@(posedge clk) disable iff (!rst_n)
    fin_v_r && !en |=> fin_v_r)
    else $error("final stage dropped an item during a stall");
`endif

endmodule

`default_nettype wire
